FILE: src/tfct_pkg.sv
package tfct_pkg;

  // default sizing
  localparam int TFCT_FRAME_BYTES = 9;
  localparam int TFCT_TIME_BITS   = 48;

  // configuration port
  localparam int TFCT_ADDR_BITS = 3;
  localparam logic TFCT_REG_QUIET_GAP = 1'b0;
  localparam logic TFCT_REG_BACKOFF   = 1'b1;
  localparam logic [15:0] TFCT_QUIET_GAP_RST = 16'd5;
  localparam logic [15:0] TFCT_BACKOFF_RST   = 16'd50;

  // event codes
  typedef enum logic [2:0] {
    OP_BEGIN  = 3'd0,
    OP_BYTE   = 3'd1,
    OP_TAKE   = 3'd2,
    OP_CANCEL = 3'd3,
    OP_EXPIRY = 3'd4
  } tfct_op_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch the incoming word
    logic calc;       // time sums and compares
    logic decide;     // begin permission
    logic commit;     // apply event, load single result
    logic emit_take;  // load one frame byte result
  } tfct_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic take_hit;    // take with a complete frame
    logic drain_last;  // drain pointer on the final byte
  } tfct_stat_t;

endpackage

FILE: src/tfct_evt_if.sv
interface tfct_evt_if import tfct_pkg::*; #(
  parameter int TIME_BITS = TFCT_TIME_BITS
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           op;
  logic [TIME_BITS-1:0] now_ms;
  logic [7:0]           rx_byte;
  logic [31:0]          measurement_id;
  logic [31:0]          attempt_no;
  logic [31:0]          timeout_ms;

  modport source (
    output valid, op, now_ms, rx_byte, measurement_id, attempt_no, timeout_ms,
    input  ready
  );
  modport sink (
    input  valid, op, now_ms, rx_byte, measurement_id, attempt_no, timeout_ms,
    output ready
  );
endinterface

FILE: src/tfct_res_if.sv
interface tfct_res_if import tfct_pkg::*; #(
  parameter int TIME_BITS = TFCT_TIME_BITS
);
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic                 can_begin;
  logic [7:0]           frame_byte;
  logic [3:0]           byte_index;
  logic                 last;
  logic [31:0]          taken_measurement;
  logic [31:0]          taken_attempt;
  logic [TIME_BITS-1:0] capture_stamp;

  modport source (
    output valid, accepted, can_begin, frame_byte, byte_index, last,
           taken_measurement, taken_attempt, capture_stamp,
    input  ready
  );
  modport sink (
    input  valid, accepted, can_begin, frame_byte, byte_index, last,
           taken_measurement, taken_attempt, capture_stamp,
    output ready
  );
endinterface

FILE: src/tfct_ram.sv
module tfct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 9,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/tfct_regs.sv
module tfct_regs import tfct_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [TFCT_ADDR_BITS-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [15:0]               quiet_gap,
  output logic [15:0]               reuse_backoff
);

  logic wr_en;
  logic reg_sel;

  // word index is address bit 2, low bits ignored
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quiet_gap     <= TFCT_QUIET_GAP_RST;
      reuse_backoff <= TFCT_BACKOFF_RST;
    end else if (wr_en) begin
      if (reg_sel == TFCT_REG_QUIET_GAP) begin
        quiet_gap <= pwdata[15:0];
      end else begin
        reuse_backoff <= pwdata[15:0];
      end
    end
  end

  // read back
  always_comb begin
    if (reg_sel == TFCT_REG_BACKOFF) begin
      prdata = {16'h0000, reuse_backoff};
    end else begin
      prdata = {16'h0000, quiet_gap};
    end
  end

endmodule

FILE: src/tfct_ctrl.sv
module tfct_ctrl import tfct_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       evt_valid,
  output logic       evt_ready,
  output logic       res_valid,
  input  logic       res_ready,
  input  tfct_stat_t stat,
  output tfct_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_DECIDE,
    S_EXEC,
    S_TAKE_RD,
    S_OUT
  } state_t;

  state_t state;
  logic   final_word;

  // sequencer, handshake flags registered
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      evt_ready  <= 1'b1;
      res_valid  <= 1'b0;
      final_word <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (evt_valid) begin
            evt_ready <= 1'b0;
            state     <= S_CALC;
          end
        end
        S_CALC: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (stat.take_hit) begin
            state <= S_TAKE_RD;
          end else begin
            res_valid  <= 1'b1;
            final_word <= 1'b1;
            state      <= S_OUT;
          end
        end
        S_TAKE_RD: begin
          res_valid  <= 1'b1;
          final_word <= stat.drain_last;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            if (final_word) begin
              evt_ready <= 1'b1;
              state     <= S_IDLE;
            end else begin
              state <= S_TAKE_RD;
            end
          end
        end
        default: begin
          state     <= S_IDLE;
          evt_ready <= 1'b1;
          res_valid <= 1'b0;
        end
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && evt_valid;
    cmd.calc      = (state == S_CALC);
    cmd.decide    = (state == S_DECIDE);
    cmd.commit    = (state == S_EXEC) && !stat.take_hit;
    cmd.emit_take = (state == S_TAKE_RD);
  end

endmodule

FILE: src/tfct_dp.sv
module tfct_dp import tfct_pkg::*; #(
  parameter int FRAME_BYTES = TFCT_FRAME_BYTES,
  parameter int TIME_BITS   = TFCT_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tfct_cmd_t            cmd,
  output tfct_stat_t           stat,
  input  logic [2:0]           op,
  input  logic [TIME_BITS-1:0] now_ms,
  input  logic [7:0]           rx_byte,
  input  logic [31:0]          measurement_id,
  input  logic [31:0]          attempt_no,
  input  logic [31:0]          timeout_ms,
  input  logic [15:0]          quiet_gap,
  input  logic [15:0]          reuse_backoff,
  output logic                 accepted,
  output logic                 can_begin,
  output logic [7:0]           frame_byte,
  output logic [3:0]           byte_index,
  output logic                 last,
  output logic [31:0]          taken_measurement,
  output logic [31:0]          taken_attempt,
  output logic [TIME_BITS-1:0] capture_stamp
);

  localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int FW = $clog2(FRAME_BYTES + 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(FRAME_BYTES);
  localparam logic [AW-1:0] IDX_LAST  = AW'(FRAME_BYTES - 1);

  // sum clamped at all ones
  function automatic logic [TIME_BITS-1:0] sat_add(
    input logic [TIME_BITS-1:0] a,
    input logic [TIME_BITS-1:0] b
  );
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

  // latched event word
  logic [2:0]           op_q;
  logic [TIME_BITS-1:0] now_q;
  logic [7:0]           rx_q;
  logic [31:0]          meas_q;
  logic [31:0]          att_q;
  logic [31:0]          tmo_q;

  // transaction state
  logic                 active;
  logic                 complete;
  logic [FW-1:0]        fill_count;
  logic [31:0]          held_measurement;
  logic [31:0]          held_attempt;
  logic [TIME_BITS-1:0] deadline;
  logic [TIME_BITS-1:0] last_rx_time;
  logic [TIME_BITS-1:0] capture_time;
  logic [TIME_BITS-1:0] reuse_after;

  // intermediate terms
  logic [TIME_BITS-1:0] quiet_until;
  logic [TIME_BITS-1:0] deadline_new;
  logic [TIME_BITS-1:0] reuse_new;
  logic                 ge_reuse;
  logic                 le_deadline;
  logic                 ge_deadline;
  logic                 can_q;

  // drain pointer and frame store
  logic [AW-1:0]        drain_idx;
  logic [AW+3:0]        idx_ext;
  logic [7:0]           ram_rdata;
  logic                 store_ok;
  logic                 ram_we;
  logic [FW-1:0]        fill_inc;

  assign store_ok = active && !complete && le_deadline && (fill_count < FILL_FULL);
  assign ram_we   = cmd.commit && (op_q == OP_BYTE) && store_ok;
  assign fill_inc = fill_count + FW'(1);
  assign idx_ext  = {4'h0, drain_idx};

  assign stat.take_hit   = (op_q == OP_TAKE) && complete;
  assign stat.drain_last = (drain_idx == IDX_LAST);

  tfct_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES),
    .AW    (AW)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_count[AW-1:0]),
    .wdata (rx_q),
    .raddr (drain_idx),
    .rdata (ram_rdata)
  );

  // event word capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op;
      now_q  <= now_ms;
      rx_q   <= rx_byte;
      meas_q <= measurement_id;
      att_q  <= attempt_no;
      tmo_q  <= timeout_ms;
    end
  end

  // time sums and compares against current state
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      quiet_until  <= sat_add(last_rx_time, TIME_BITS'(quiet_gap));
      deadline_new <= sat_add(now_q, TIME_BITS'(tmo_q));
      reuse_new    <= sat_add(now_q, TIME_BITS'(reuse_backoff));
      ge_reuse     <= (now_q >= reuse_after);
      le_deadline  <= (now_q <= deadline);
      ge_deadline  <= (now_q >= deadline);
    end
  end

  // begin permission, judged on state before the event
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      can_q <= !active && !complete && ge_reuse &&
               ((last_rx_time == '0) || (now_q >= quiet_until));
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      active           <= 1'b0;
      complete         <= 1'b0;
      fill_count       <= '0;
      held_measurement <= '0;
      held_attempt     <= '0;
      deadline         <= '0;
      last_rx_time     <= '0;
      capture_time     <= '0;
      reuse_after      <= '0;
      drain_idx        <= '0;
    end else if (cmd.commit) begin
      case (op_q)
        OP_BEGIN: begin
          if ((att_q != '0) && (tmo_q != '0) && can_q) begin
            held_measurement <= meas_q;
            held_attempt     <= att_q;
            deadline         <= deadline_new;
            fill_count       <= '0;
            complete         <= 1'b0;
            active           <= 1'b1;
          end
        end
        OP_BYTE: begin
          last_rx_time <= now_q;
          if (store_ok) begin
            fill_count <= fill_inc;
            if (fill_inc == FILL_FULL) begin
              capture_time <= now_q;
              complete     <= 1'b1;
            end
          end
        end
        OP_CANCEL: begin
          active      <= 1'b0;
          complete    <= 1'b0;
          fill_count  <= '0;
          reuse_after <= reuse_new;
        end
        OP_EXPIRY: begin
          if (active && !complete && ge_deadline) begin
            active      <= 1'b0;
            complete    <= 1'b0;
            fill_count  <= '0;
            reuse_after <= reuse_new;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.emit_take) begin
      // the final byte frees the block
      if (stat.drain_last) begin
        drain_idx  <= '0;
        active     <= 1'b0;
        complete   <= 1'b0;
        fill_count <= '0;
      end else begin
        drain_idx <= drain_idx + AW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      case (op_q)
        OP_BEGIN:  accepted <= (att_q != '0) && (tmo_q != '0) && can_q;
        OP_EXPIRY: accepted <= active && !complete && ge_deadline;
        default:   accepted <= 1'b0;
      endcase
      can_begin         <= can_q;
      frame_byte        <= '0;
      byte_index        <= '0;
      last              <= 1'b1;
      taken_measurement <= '0;
      taken_attempt     <= '0;
      capture_stamp     <= '0;
    end else if (cmd.emit_take) begin
      accepted          <= 1'b1;
      can_begin         <= can_q;
      frame_byte        <= ram_rdata;
      byte_index        <= idx_ext[3:0];
      last              <= stat.drain_last;
      taken_measurement <= held_measurement;
      taken_attempt     <= held_attempt;
      capture_stamp     <= capture_time;
    end
  end

endmodule

FILE: src/timed_frame_capture_transaction.sv
// Channel  Dir  Handshake      Word
// evt      in   valid/ready    op, now_ms, rx_byte, measurement_id, attempt_no, timeout_ms
// res      out  valid/ready    accepted, can_begin, frame_byte, byte_index, last,
//                              taken_measurement, taken_attempt, capture_stamp
// apb      in   psel/penable   quiet_gap_ms at 0x0, reuse_backoff_ms at 0x4
//
// One event at a time: accept, time sums, permission, update, then the result.
// A single-result event returns one word; a take of a full frame returns one
// word per byte, each read from the registered frame RAM.
// rst is synchronous; it clears the sequencer and transaction state, the
// frame RAM holds no reset. A stalled res holds the word and evt stays low.
module timed_frame_capture_transaction import tfct_pkg::*; #(
  parameter int FRAME_BYTES = TFCT_FRAME_BYTES,
  parameter int TIME_BITS   = TFCT_TIME_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  tfct_evt_if.sink                  evt,
  tfct_res_if.source                res,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [TFCT_ADDR_BITS-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  tfct_cmd_t   cmd;
  tfct_stat_t  stat;
  logic [15:0] quiet_gap;
  logic [15:0] reuse_backoff;

  tfct_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .quiet_gap     (quiet_gap),
    .reuse_backoff (reuse_backoff)
  );

  tfct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tfct_dp #(
    .FRAME_BYTES (FRAME_BYTES),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .op                (evt.op),
    .now_ms            (evt.now_ms),
    .rx_byte           (evt.rx_byte),
    .measurement_id    (evt.measurement_id),
    .attempt_no        (evt.attempt_no),
    .timeout_ms        (evt.timeout_ms),
    .quiet_gap         (quiet_gap),
    .reuse_backoff     (reuse_backoff),
    .accepted          (res.accepted),
    .can_begin         (res.can_begin),
    .frame_byte        (res.frame_byte),
    .byte_index        (res.byte_index),
    .last              (res.last),
    .taken_measurement (res.taken_measurement),
    .taken_attempt     (res.taken_attempt),
    .capture_stamp     (res.capture_stamp)
  );

`ifndef NO_ASSERTIONS
  // no new event while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !evt.ready)
    else $error("event accepted while a result is pending");

  // only a take emits more than one word, and those are accepted words
  a_multi_is_take: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.last) |-> res.accepted)
    else $error("non-final result word that is not a take byte");

  // after a non-final word the event side stays closed
  a_drain_holds: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ready && !res.last) |=> !evt.ready)
    else $error("event side reopened in the middle of a frame drain");
`endif

endmodule
